>>> sv/fpla_pkg.sv
`default_nettype none

package fpla_pkg;

	// field and register widths
	localparam int CNT_W  = 21;
	localparam int RAW_W  = CNT_W - 1;
	localparam int PER_W  = 16;
	localparam int AVG_W  = 32;
	localparam int CFG_W  = 12;
	localparam int IDX_W  = 2;
	localparam int LANE_W = 2;

	localparam int FRAC_BITS_DEF = 11;

	// register indexes, also the lane numbers
	localparam logic [IDX_W-1:0] REG_DECAY_SHORT  = 2'd0;
	localparam logic [IDX_W-1:0] REG_DECAY_MEDIUM = 2'd1;
	localparam logic [IDX_W-1:0] REG_DECAY_LONG   = 2'd2;

	localparam logic [LANE_W-1:0] LANE_FIRST = 2'd0;
	localparam logic [LANE_W-1:0] LANE_LAST  = 2'd2;

	localparam logic [CFG_W-1:0] DECAY_SHORT_RST  = 12'd1884;
	localparam logic [CFG_W-1:0] DECAY_MEDIUM_RST = 12'd2014;
	localparam logic [CFG_W-1:0] DECAY_LONG_RST   = 12'd2037;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_POW,
		ST_MUL,
		ST_WRITE,
		ST_DONE
	} fpla_state_t;

	typedef struct packed {
		logic              capture;
		logic              pow_init;
		logic              pow_step;
		logic              blend_mul;
		logic              blend_wr;
		logic              out_load;
		logic [LANE_W-1:0] lane;
	} fpla_cmd_t;

	typedef struct packed {
		logic pow_done;
	} fpla_sts_t;

endpackage

`default_nettype wire

>>> sv/fixed_point_load_average.sv
// channel  | handshake              | payload
// ---------+------------------------+-------------------------------------------
// input    | in_valid / in_ready    | active_count (21, signed), periods (16)
// output   | out_valid / out_ready  | avg_short, avg_medium, avg_long (32 each)
// config   | cfg_we                 | cfg_index (2), cfg_data (12)
//
// one word at a time; each of the three averages takes one squaring step per exponent
// bit of periods in the shared square-and-multiply loop, then a multiply and a write-back;
// the word is accepted before the first average and handed over after the last
// reset clears the averages to zero and loads the default decay factors
// a finished word waits in the output register while the next word is accepted;
// the next result is held back only if that register is still full
`default_nettype none

module fixed_point_load_average #(
	parameter int FRAC_BITS = fpla_pkg::FRAC_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// configuration writes
	input  wire                              cfg_we,
	input  wire [fpla_pkg::IDX_W-1:0]        cfg_index,
	input  wire [fpla_pkg::CFG_W-1:0]        cfg_data,
	// input words
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire signed [fpla_pkg::CNT_W-1:0] active_count,
	input  wire [fpla_pkg::PER_W-1:0]        periods,
	// result words
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [fpla_pkg::AVG_W-1:0]       avg_short,
	output logic [fpla_pkg::AVG_W-1:0]       avg_medium,
	output logic [fpla_pkg::AVG_W-1:0]       avg_long
);

	// command and status between sequencer and datapath
	fpla_pkg::fpla_cmd_t cmd;
	fpla_pkg::fpla_sts_t sts;

	// sequencer: steps the three lanes through power, multiply and write-back
	fpla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: decay registers, power unit, blend multipliers, averages
	fpla_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.active_count (active_count),
		.periods      (periods),
		.cmd          (cmd),
		.sts          (sts),
		.avg_short    (avg_short),
		.avg_medium   (avg_medium),
		.avg_long     (avg_long)
	);

endmodule

`default_nettype wire

>>> sv/fpla_ctrl.sv
`default_nettype none

module fpla_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire                  out_ready,
	input  fpla_pkg::fpla_sts_t  sts,
	output fpla_pkg::fpla_cmd_t  cmd
);

	fpla_pkg::fpla_state_t state_q, state_n;
	logic [fpla_pkg::LANE_W-1:0] lane_q, lane_n;
	logic out_valid_q, out_valid_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpla_pkg::ST_IDLE;
			lane_q      <= fpla_pkg::LANE_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			lane_q      <= lane_n;
			out_valid_q <= out_valid_n;
		end
	end

	always_comb begin
		state_n       = state_q;
		lane_n        = lane_q;
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.lane      = lane_q;
		out_valid_n   = out_valid_q & ~out_ready;
		case (state_q)
			fpla_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					lane_n      = fpla_pkg::LANE_FIRST;
					state_n     = fpla_pkg::ST_LOAD;
				end
			end
			fpla_pkg::ST_LOAD: begin
				cmd.pow_init = 1'b1;
				state_n      = fpla_pkg::ST_POW;
			end
			fpla_pkg::ST_POW: begin
				if (sts.pow_done) begin
					state_n = fpla_pkg::ST_MUL;
				end else begin
					cmd.pow_step = 1'b1;
				end
			end
			fpla_pkg::ST_MUL: begin
				cmd.blend_mul = 1'b1;
				state_n       = fpla_pkg::ST_WRITE;
			end
			fpla_pkg::ST_WRITE: begin
				cmd.blend_wr = 1'b1;
				if (lane_q == fpla_pkg::LANE_LAST) begin
					state_n = fpla_pkg::ST_DONE;
				end else begin
					lane_n  = lane_q + 1'b1;
					state_n = fpla_pkg::ST_LOAD;
				end
			end
			fpla_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_n  = 1'b1;
					state_n      = fpla_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = fpla_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	// a waiting result word is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result word overwritten while waiting");

	// lane counter stays within the three averages
	a_lane_range: assert property (@(posedge clk) disable iff (!arst_n)
		lane_q != 2'd3)
		else $error("lane counter out of range");

	// an accepted word starts with the first lane
	a_start_lane: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == fpla_pkg::ST_LOAD &&
		lane_q == fpla_pkg::LANE_FIRST))
		else $error("item did not start on the first lane");

	// no squaring step once the exponent is used up
	a_step_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pow_step |-> !sts.pow_done)
		else $error("power step issued with exponent exhausted");

endmodule

`default_nettype wire

>>> sv/fpla_dp.sv
`default_nettype none

module fpla_dp #(
	parameter int FRAC_BITS = fpla_pkg::FRAC_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [fpla_pkg::IDX_W-1:0]    cfg_index,
	input  wire [fpla_pkg::CFG_W-1:0]    cfg_data,
	input  wire signed [fpla_pkg::CNT_W-1:0] active_count,
	input  wire [fpla_pkg::PER_W-1:0]    periods,
	input  fpla_pkg::fpla_cmd_t          cmd,
	output fpla_pkg::fpla_sts_t          sts,
	output logic [fpla_pkg::AVG_W-1:0]   avg_short,
	output logic [fpla_pkg::AVG_W-1:0]   avg_medium,
	output logic [fpla_pkg::AVG_W-1:0]   avg_long
);

	localparam int EW  = FRAC_BITS + 1;
	localparam int PW  = 2 * EW;
	localparam int CW  = (EW > fpla_pkg::CFG_W) ? EW : fpla_pkg::CFG_W;
	localparam int P1W = fpla_pkg::AVG_W + EW;
	localparam int P2W = fpla_pkg::RAW_W + EW;
	localparam int SW  = ((P1W > P2W + FRAC_BITS) ? P1W : P2W + FRAC_BITS) + 1;
	localparam int RW  = SW - FRAC_BITS;

	localparam logic [EW-1:0] ONE_E  = EW'(1) << FRAC_BITS;
	localparam logic [CW-1:0] ONE_C  = CW'(1) << FRAC_BITS;
	localparam logic [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);
	localparam logic [SW-1:0] HALF_S = SW'(1) << (FRAC_BITS - 1);

	logic [fpla_pkg::CFG_W-1:0] decay_q [3];
	logic [fpla_pkg::AVG_W-1:0] avg_q [3];
	logic [fpla_pkg::RAW_W-1:0] raw_q;
	logic [fpla_pkg::PER_W-1:0] periods_q;
	logic [fpla_pkg::PER_W-1:0] n_q;
	logic [EW-1:0]              acc_q, base_q;
	logic [P1W-1:0]             p1_q;
	logic [P2W-1:0]             p2_q;

	logic [CW-1:0]              dec_ext, dec_clamp;
	logic [PW-1:0]              acc_prod, base_prod;
	logic [EW-1:0]              acc_rnd, base_rnd;
	logic [EW-1:0]              one_minus;
	logic [SW-1:0]              sum;
	logic [RW-1:0]              shifted;
	logic [fpla_pkg::AVG_W-1:0] blended;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q[0] <= fpla_pkg::DECAY_SHORT_RST;
			decay_q[1] <= fpla_pkg::DECAY_MEDIUM_RST;
			decay_q[2] <= fpla_pkg::DECAY_LONG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fpla_pkg::REG_DECAY_SHORT:  decay_q[0] <= cfg_data;
				fpla_pkg::REG_DECAY_MEDIUM: decay_q[1] <= cfg_data;
				fpla_pkg::REG_DECAY_LONG:   decay_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// decay above one counts as one
	assign dec_ext   = CW'(decay_q[cmd.lane]);
	assign dec_clamp = (dec_ext > ONE_C) ? ONE_C : dec_ext;

	// rounded products for square-and-multiply
	assign acc_prod  = PW'(acc_q) * PW'(base_q) + HALF_P;
	assign base_prod = PW'(base_q) * PW'(base_q) + HALF_P;
	assign acc_rnd   = acc_prod[FRAC_BITS +: EW];
	assign base_rnd  = base_prod[FRAC_BITS +: EW];

	assign one_minus = ONE_E - acc_q;

	// blend sum, rounded and saturated
	assign sum     = SW'(p1_q) + (SW'(p2_q) << FRAC_BITS) + HALF_S;
	assign shifted = sum[SW-1:FRAC_BITS];
	assign blended = (|shifted[RW-1:fpla_pkg::AVG_W]) ? '1 : shifted[fpla_pkg::AVG_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			raw_q     <= active_count[fpla_pkg::CNT_W-1] ? '0 :
				active_count[fpla_pkg::RAW_W-1:0];
			periods_q <= periods;
		end
		if (cmd.pow_init) begin
			acc_q  <= ONE_E;
			base_q <= dec_clamp[EW-1:0];
			n_q    <= periods_q;
		end else if (cmd.pow_step) begin
			if (n_q[0]) begin
				acc_q <= acc_rnd;
			end
			base_q <= base_rnd;
			n_q    <= n_q >> 1;
		end
		if (cmd.blend_mul) begin
			p1_q <= P1W'(avg_q[cmd.lane]) * P1W'(acc_q);
			p2_q <= P2W'(raw_q) * P2W'(one_minus);
		end
		if (cmd.out_load) begin
			avg_short  <= avg_q[0];
			avg_medium <= avg_q[1];
			avg_long   <= avg_q[2];
		end
	end

	// the three running averages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q[0] <= '0;
			avg_q[1] <= '0;
			avg_q[2] <= '0;
		end else if (cmd.blend_wr) begin
			avg_q[cmd.lane] <= blended;
		end
	end

	assign sts.pow_done = (n_q == '0);

endmodule

`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	import fpla_pkg::*;

	// fixed-point unit of the averages, the same as the block's default
	localparam int          FRAC        = FRAC_BITS_DEF;
	localparam logic [63:0] FX_ONE      = 64'd1 << FRAC;
	localparam logic [63:0] FX_HALF     = 64'd1 << (FRAC - 1);
	localparam logic [63:0] AVG_SAT     = 64'h0000_0000_FFFF_FFFF;
	// index past the last decay register, writes to it must be ignored
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
	// the tail wait covers the slowest word with margin
	localparam int          SETTLE      = 4;
	localparam int          TAIL_CYCLES = 100;
	localparam int          CYCLE_LIMIT = 1_000_000;
	localparam int          RAND_PHASES = 5;
	localparam int          PHASE_WORDS = 230;

	typedef struct packed {
		logic [AVG_W-1:0] avg_short;
		logic [AVG_W-1:0] avg_medium;
		logic [AVG_W-1:0] avg_long;
	} avg_triple_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_we;
	logic [IDX_W-1:0]        cfg_index;
	logic [CFG_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic signed [CNT_W-1:0] active_count;
	logic [PER_W-1:0]        periods;
	logic                    out_valid;
	logic                    out_ready;
	logic [AVG_W-1:0]        avg_short;
	logic [AVG_W-1:0]        avg_medium;
	logic [AVG_W-1:0]        avg_long;

	// own copy of the block's state: decay registers and the three averages
	logic [CFG_W-1:0] decay_fx [3];
	logic [AVG_W-1:0] avg_fx [3];

	// averages predicted for accepted words, oldest first
	avg_triple_t predicted_avgs_q [$];

	int  error_count = 0;
	int  cycle_count = 0;
	// set to start no new gaps or stalls on either side
	bit  no_gaps     = 1'b0;
	int  stall_left  = 0;

	fixed_point_load_average i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.active_count (active_count),
		.periods      (periods),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.avg_short    (avg_short),
		.avg_medium   (avg_medium),
		.avg_long     (avg_long)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// product of two fixed-point values, rounded to nearest
	function automatic logic [63:0] fx_round_mul(input logic [63:0] a, input logic [63:0] b);
		return (a * b + FX_HALF) >> FRAC;
	endfunction

	// decay raised to the number of periods, square-and-multiply from the lsb up
	function automatic logic [63:0] fx_decay_power(input logic [63:0] base,
			input logic [PER_W-1:0] n);
		logic [63:0] acc;
		acc = FX_ONE;
		while (n != '0) begin
			if (n[0])
				acc = fx_round_mul(acc, base);
			n = n >> 1;
			// no squaring after the top bit, so rounding matches the block
			if (n != '0)
				base = fx_round_mul(base, base);
		end
		return acc;
	endfunction

	// pull one average toward the scaled count, saturating at the top
	function automatic logic [AVG_W-1:0] fx_blend(input logic [AVG_W-1:0] avg,
			input logic [63:0] e, input logic [63:0] cnt);
		logic [63:0] sum;
		logic [63:0] r;
		sum = {32'd0, avg} * e + cnt * (FX_ONE - e) + FX_HALF;
		r = sum >> FRAC;
		return (r > AVG_SAT) ? AVG_SAT[AVG_W-1:0] : r[AVG_W-1:0];
	endfunction

	// updates the averages for one word and returns what the block should hand over
	function automatic avg_triple_t predict_averages(input logic signed [CNT_W-1:0] cnt_in,
			input logic [PER_W-1:0] per);
		logic [63:0]  cnt;
		logic [63:0]  e;
		avg_triple_t  res;
		// negative counts are clamped to zero
		cnt = cnt_in[CNT_W-1] ? 64'd0 : (64'(cnt_in[RAW_W-1:0]) << FRAC);
		for (int lane = 0; lane < 3; lane++) begin
			e = 64'(decay_fx[lane]);
			if (e > FX_ONE)
				e = FX_ONE;
			e = fx_decay_power(e, per);
			avg_fx[lane] = fx_blend(avg_fx[lane], e, cnt);
		end
		res.avg_short  = avg_fx[REG_DECAY_SHORT];
		res.avg_medium = avg_fx[REG_DECAY_MEDIUM];
		res.avg_long   = avg_fx[REG_DECAY_LONG];
		return res;
	endfunction

	// ------------------------------------------------------------------
	// gaps and handshakes
	// ------------------------------------------------------------------

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 3);
		else if (r < 92)
			return $urandom_range(4, 15);
		else
			return $urandom_range(16, 80);
	endfunction

	// sends one word; valid drops at the falling edge after the handshake
	task automatic send_word(input logic signed [CNT_W-1:0] cnt, input logic [PER_W-1:0] per);
		int gap;
		gap = (!no_gaps && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     = 1'b1;
		active_count = cnt;
		periods      = per;
		do
			@(posedge clk);
		while (!in_ready);
		predicted_avgs_q.push_back(predict_averages(cnt, per));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// drops valid and waits until every predicted word has come back
	task automatic wait_drained();
		in_valid = 1'b0;
		while (predicted_avgs_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// register write, only called with the block idle
	task automatic write_decay(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we    = 1'b0;
		if (idx <= REG_DECAY_LONG)
			decay_fx[idx] = value;
	endtask

	task automatic write_all_decays(input logic [CFG_W-1:0] d_short,
			input logic [CFG_W-1:0] d_medium, input logic [CFG_W-1:0] d_long);
		write_decay(REG_DECAY_SHORT, d_short);
		write_decay(REG_DECAY_MEDIUM, d_medium);
		write_decay(REG_DECAY_LONG, d_long);
	endtask

	// receiver side: random stalls, none started while no_gaps is set
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else begin
			out_ready = 1'b1;
			if (!no_gaps && $urandom_range(0, 99) < 25)
				stall_left = pick_gap();
		end
	end

	// every result word is compared with the oldest prediction
	always @(posedge clk) begin : check_results
		avg_triple_t want;
		if (arst_n && out_valid && out_ready) begin
			if (predicted_avgs_q.size() == 0) begin
				$error("result word with no prediction waiting");
				error_count++;
			end else begin
				want = predicted_avgs_q.pop_front();
				if (avg_short !== want.avg_short) begin
					$error("avg_short: expected %0h, got %0h", want.avg_short, avg_short);
					error_count++;
				end
				if (avg_medium !== want.avg_medium) begin
					$error("avg_medium: expected %0h, got %0h", want.avg_medium, avg_medium);
					error_count++;
				end
				if (avg_long !== want.avg_long) begin
					$error("avg_long: expected %0h, got %0h", want.avg_long, avg_long);
					error_count++;
				end
			end
		end
	end

	// run limit, well beyond the slowest correct run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** fixed_point_load_average: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// default decay factors straight after reset
	task automatic test_reset_defaults();
		send_word(21'sd0, 16'd0);            // zero periods on cleared averages
		send_word(21'sd1, 16'd1);
		send_word(21'sd1048575, 16'd1);      // largest count
		send_word(21'sd1048575, 16'd0);      // zero periods keeps the averages
		send_word(-21'sd1, 16'd1);           // negative count taken as zero
		send_word({1'b1, 20'd0}, 16'd3);     // most negative count
		send_word(21'sd12, 16'd65535);       // largest period count
		send_word(21'sd0, 16'd2);
		wait_drained();
	endtask

	// decay factors of zero, exactly one and above one, and an ignored register index
	task automatic test_decay_extremes();
		write_all_decays(12'd0, 12'd0, 12'd0);
		send_word(21'sd100, 16'd1);
		send_word(21'sd100, 16'd0);
		send_word(21'sd0, 16'd2);
		wait_drained();

		// decay of one holds every average fixed
		write_all_decays(12'd2048, 12'd2048, 12'd2048);
		send_word(21'sd500, 16'd5);
		send_word(21'sd7, 16'd65535);
		send_word(21'sd1048575, 16'd1);
		wait_drained();

		// above one is clamped to one
		write_all_decays(12'd4095, 12'd4095, 12'd4095);
		send_word(21'sd3, 16'd1);
		send_word(21'sd0, 16'd300);
		wait_drained();

		write_all_decays(12'd1, 12'd2047, 12'd2049);
		send_word(21'sd200, 16'd1);
		send_word(21'sd200, 16'd2);
		send_word(21'sd9, 16'd40000);
		wait_drained();

		// write to the unused index must not touch any decay
		write_decay(REG_UNUSED, 12'd0);
		send_word(21'sd50, 16'd1);
		wait_drained();
	endtask

	function automatic logic [CFG_W-1:0] random_decay();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return 12'd0;
		else if (r < 8)
			return 12'd1;
		else if (r < 12)
			return 12'd2047;
		else if (r < 16)
			return 12'd2048;
		else if (r < 25)
			return CFG_W'($urandom_range(2049, 4095));
		else
			return CFG_W'($urandom_range(1700, 2047));
	endfunction

	function automatic logic signed [CNT_W-1:0] random_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return CNT_W'($urandom_range(0, 64));
		else if (r < 65)
			return CNT_W'($urandom_range(0, 4095));
		else if (r < 80)
			return {1'b1, RAW_W'($urandom())};
		else
			return CNT_W'($urandom());
	endfunction

	// most updates cover a few periods, some are long sleeps
	function automatic logic [PER_W-1:0] random_periods();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		else if (r < 70)
			return PER_W'($urandom_range(1, 8));
		else if (r < 90)
			return PER_W'($urandom_range(9, 255));
		else
			return PER_W'($urandom());
	endfunction

	// random updates over several decay settings
	task automatic test_random_updates();
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			write_all_decays(random_decay(), random_decay(), random_decay());
			if ($urandom_range(0, 1))
				write_decay(REG_UNUSED, CFG_W'($urandom()));
			for (int w = 0; w < PHASE_WORDS; w++) begin
				// a stretch of back-to-back words with no new receiver stalls started
				no_gaps = (w >= 40 && w < 80);
				// sender holds off until the block has emptied
				if (w == PHASE_WORDS / 2)
					wait_drained();
				send_word(random_count(), random_periods());
			end
			no_gaps = 1'b0;
			wait_drained();
		end
		// leave the block on its reset factors
		write_all_decays(DECAY_SHORT_RST, DECAY_MEDIUM_RST, DECAY_LONG_RST);
		for (int w = 0; w < 20; w++)
			send_word(random_count(), random_periods());
		wait_drained();
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_DECAY_SHORT;
		cfg_data     = '0;
		in_valid     = 1'b0;
		active_count = '0;
		periods      = '0;
		out_ready    = 1'b0;
		decay_fx[REG_DECAY_SHORT]  = DECAY_SHORT_RST;
		decay_fx[REG_DECAY_MEDIUM] = DECAY_MEDIUM_RST;
		decay_fx[REG_DECAY_LONG]   = DECAY_LONG_RST;
		for (int lane = 0; lane < 3; lane++)
			avg_fx[lane] = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_decay_extremes();
		test_random_updates();

		// quiet tail to catch stray result words
		repeat (TAIL_CYCLES) @(posedge clk);
		if (predicted_avgs_q.size() != 0) begin
			$error("%0d predicted words never arrived", predicted_avgs_q.size());
			error_count++;
		end
		if (error_count == 0)
			$display("** fixed_point_load_average: PASSED **");
		else
			$display("** fixed_point_load_average: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
sv/fpla_pkg.sv
sv/fpla_ctrl.sv
sv/fpla_dp.sv
sv/fixed_point_load_average.sv
verif/tb_top.sv
